// ===== hdl/assert_macros.svh =====
// assertion helpers, empty when SYNTH is set
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ZWA_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("zwa assertion failed");
`define ZWA_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("zwa assertion failed");
`else
`define ZWA_ASSERT(label, clk, rst, prop)
`define ZWA_ASSERT_NEVER(label, clk, rst, cond)
`endif

`endif

// ===== hdl/zwa_pkg.sv =====
`timescale 1ns / 1ps

package zwa_pkg;

   localparam int COUNT_W  = 24;
   localparam int VALUE_W  = 32;
   localparam int NULLS_W  = 24;
   localparam int CELLS_W  = 32;
   localparam int SUM_W    = 64;
   localparam int KIND_W   = 2;
   localparam int FRAC_W   = 17;
   localparam int CSR_IDX_W = 2;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 32;
   localparam int DIV_STEPS = 64;

   localparam logic [KIND_W-1:0] KIND_AVG = 2'd0;
   localparam logic [KIND_W-1:0] KIND_MIN = 2'd1;
   localparam logic [KIND_W-1:0] KIND_MAX = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_KIND   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAC   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NODATA = 2'd2;

   // -9999.0 in Q16.16
   localparam logic [VALUE_W-1:0] NODATA_RESET = 32'hD8F10000;

   // one finished zone handed from the accumulator to the result unit
   typedef struct packed {
      logic signed [SUM_W-1:0]   sum;
      logic [CELLS_W-1:0]        valid;
      logic [CELLS_W-1:0]        nulls;
      logic signed [VALUE_W-1:0] extreme;
      logic [KIND_W-1:0]         kind;
   } zone_type;

endpackage

// ===== hdl/zonal_weighted_aggregate.sv =====
`timescale 1ns / 1ps
// path: a zone's last item is registered and pushed into the queue; the result unit pops
// it, tests the threshold, for the average runs the one-bit-a-step divider, then registers
// the result; the accumulator takes one item per cycle, but a closing item waits while the
// queue is full; the result unit takes one zone at a time, so shorter zones fill the queue
// reset: synchronous, active high; clears the pipeline, queue, result unit and sets
// the registers to average, threshold 0 and nodata -9999.0
module zonal_weighted_aggregate #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // cell_count [23:0], sample_value [55:24], starting_nulls [79:56]
   input  logic [zwa_pkg::REQ_DATA_W-1:0]      req_tdata,
   // zone_last
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // zone_result [31:0]
   output logic [zwa_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // zone_valid [0]
   output logic                                rsp_tuser,
   input  logic                                csr_we,
   input  logic [zwa_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [zwa_pkg::VALUE_W-1:0]         csr_wdata
);

   logic [zwa_pkg::KIND_W-1:0]  kind_ff;
   logic [zwa_pkg::FRAC_W-1:0]  frac_ff;
   logic [zwa_pkg::VALUE_W-1:0] nodata_ff;

   logic              q_full, q_empty, q_push, q_pop;
   zwa_pkg::zone_type q_entry, q_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff   <= zwa_pkg::KIND_AVG;
         frac_ff   <= '0;
         nodata_ff <= zwa_pkg::NODATA_RESET;
      end else if (csr_we) begin
         priority if (csr_index == zwa_pkg::CSR_KIND) begin
            kind_ff <= csr_wdata[zwa_pkg::KIND_W-1:0];
         end else if (csr_index == zwa_pkg::CSR_FRAC) begin
            frac_ff <= csr_wdata[zwa_pkg::FRAC_W-1:0];
         end else if (csr_index == zwa_pkg::CSR_NODATA) begin
            nodata_ff <= csr_wdata;
         end
      end
   end

   zwa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .kind       (kind_ff),
      .nodata     (nodata_ff),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (q_entry)
   );

   zwa_queue #(
      .Depth (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .empty      (q_empty),
      .head       (q_head)
   );

   zwa_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .frac_min   (frac_ff),
      .nodata     (nodata_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== hdl/zwa_front.sv =====
`timescale 1ns / 1ps

module zwa_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // cell_count [23:0], sample_value [55:24], starting_nulls [79:56]
   input  logic [zwa_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                              req_tlast,
   input  logic [zwa_pkg::KIND_W-1:0]        kind,
   input  logic [zwa_pkg::VALUE_W-1:0]       nodata,
   input  logic                              q_full,
   output logic                              q_push,
   output zwa_pkg::zone_type                 q_entry
);

   localparam int ProdW = zwa_pkg::COUNT_W + 1 + zwa_pkg::VALUE_W;

   logic                               a_valid_ff;
   logic [zwa_pkg::COUNT_W-1:0]        a_count_ff;
   logic signed [zwa_pkg::VALUE_W-1:0] a_value_ff;
   logic [zwa_pkg::NULLS_W-1:0]        a_nulls_ff;
   logic                               a_last_ff;
   logic signed [ProdW-1:0]            a_prod_ff;
   logic signed [ProdW-1:0]            prod_in;

   logic signed [zwa_pkg::SUM_W-1:0]   sum_ff, sum_in, base_sum;
   logic [zwa_pkg::CELLS_W-1:0]        valid_ff, valid_in, base_valid;
   logic [zwa_pkg::CELLS_W-1:0]        null_ff, null_in, base_null;
   logic signed [zwa_pkg::VALUE_W-1:0] ext_ff, ext_in, base_ext, ext_start;
   logic                               seen_ff, seen_in, base_seen;
   logic                               zone_start_ff;
   logic                               advance, fire;

   function automatic logic [31:0] sat_add_u32(input logic [31:0] a, input logic [23:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {9'b0, b};
      return s[32] ? 32'hFFFFFFFF : s[31:0];
   endfunction

   function automatic logic signed [63:0] sat_add_s64(input logic signed [63:0] a,
                                                       input logic signed [63:0] b);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         return s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
      end
      return s[63:0];
   endfunction

   assign prod_in = $signed({1'b0, req_tdata[23:0]}) * $signed(req_tdata[55:24]);

   // a closing item waits while the queue has no room
   assign advance    = !(a_last_ff && q_full);
   assign fire       = a_valid_ff && advance;
   assign req_tready = !a_valid_ff || advance;
   assign q_push     = fire && a_last_ff;

   always_comb begin
      base_sum   = zone_start_ff ? '0 : sum_ff;
      base_valid = zone_start_ff ? '0 : valid_ff;
      base_null  = zone_start_ff ? {8'b0, a_nulls_ff} : null_ff;
      base_ext   = zone_start_ff ? $signed(nodata) : ext_ff;
      base_seen  = zone_start_ff ? 1'b0 : seen_ff;
      ext_start  = base_seen ? base_ext : a_value_ff;

      sum_in   = base_sum;
      valid_in = base_valid;
      null_in  = base_null;
      ext_in   = base_ext;
      seen_in  = base_seen;

      if (a_count_ff != '0) begin
         if (a_value_ff == $signed(nodata)) begin
            null_in = sat_add_u32(base_null, a_count_ff);
         end else begin
            valid_in = sat_add_u32(base_valid, a_count_ff);
            seen_in  = 1'b1;
            ext_in   = ext_start;
            priority if (kind == zwa_pkg::KIND_AVG) begin
               sum_in = sat_add_s64(base_sum, {{(zwa_pkg::SUM_W-ProdW){a_prod_ff[ProdW-1]}},
                                               a_prod_ff});
            end else if (kind == zwa_pkg::KIND_MIN) begin
               if (a_value_ff < ext_start) ext_in = a_value_ff;
            end else if (kind == zwa_pkg::KIND_MAX) begin
               if (a_value_ff > ext_start) ext_in = a_value_ff;
            end else begin
               ext_in = ext_start;
            end
         end
      end

      q_entry.sum     = sum_in;
      q_entry.valid   = valid_in;
      q_entry.nulls   = null_in;
      q_entry.extreme = ext_in;
      q_entry.kind    = kind;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff    <= 1'b0;
         zone_start_ff <= 1'b1;
      end else begin
         if (req_tready) a_valid_ff <= req_tvalid;
         if (fire) zone_start_ff <= a_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         a_count_ff <= req_tdata[23:0];
         a_value_ff <= req_tdata[55:24];
         a_nulls_ff <= req_tdata[79:56];
         a_last_ff  <= req_tlast;
         a_prod_ff  <= prod_in;
      end
      if (fire) begin
         sum_ff   <= sum_in;
         valid_ff <= valid_in;
         null_ff  <= null_in;
         ext_ff   <= ext_in;
         seen_ff  <= seen_in;
      end
   end

endmodule

// ===== hdl/zwa_queue.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module zwa_queue #(
   parameter int Depth = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  zwa_pkg::zone_type push_entry,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output zwa_pkg::zone_type head
);

   localparam int PtrW = $clog2(Depth);
   localparam int CntW = $clog2(Depth + 1);

   zwa_pkg::zone_type mem [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0]   count_ff;

   function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
      return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full  = (count_ff == CntW'(Depth));
   assign empty = (count_ff == '0);
   assign head  = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= next_ptr(wr_ptr_ff);
         if (pop) rd_ptr_ff <= next_ptr(rd_ptr_ff);
         if (push && !pop) count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem[wr_ptr_ff] <= push_entry;
   end

   `ZWA_ASSERT_NEVER(a_push_when_full, clock, reset, push && full)
   `ZWA_ASSERT_NEVER(a_pop_when_empty, clock, reset, pop && empty)
   `ZWA_ASSERT(a_push_fills, clock, reset, push |=> !empty)

endmodule

// ===== hdl/zwa_back.sv =====
`timescale 1ns / 1ps

module zwa_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_empty,
   input  zwa_pkg::zone_type            q_head,
   output logic                         q_pop,
   input  logic [zwa_pkg::FRAC_W-1:0]   frac_min,
   input  logic [zwa_pkg::VALUE_W-1:0]  nodata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // zone_result [31:0]
   output logic [zwa_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // zone_valid [0]
   output logic                         rsp_tuser
);

   localparam int CellsW = zwa_pkg::CELLS_W;
   localparam int SumW   = zwa_pkg::SUM_W;
   localparam int ThrW   = zwa_pkg::FRAC_W + CellsW + 1;
   localparam int StepW  = $clog2(zwa_pkg::DIV_STEPS);

   typedef enum logic [2:0] {
      ST_IDLE, ST_TEST, ST_CMP, ST_DIV, ST_SAT, ST_DONE
   } state_type;

   state_type                   state_ff;
   logic                        neg_ff;
   logic [SumW-1:0]             dvd_ff;
   logic [CellsW-1:0]           rem_ff;
   logic [CellsW-1:0]           divisor_ff;
   logic [CellsW-1:0]           nulls_ff;
   logic [zwa_pkg::VALUE_W-1:0] ext_ff;
   logic [zwa_pkg::KIND_W-1:0]  kind_ff;
   logic [ThrW-1:0]             thr_ff;
   logic [StepW-1:0]            step_ff;
   logic [zwa_pkg::VALUE_W-1:0] res_ff;
   logic                        ok_ff;
   logic                        rsp_valid_ff;
   logic [zwa_pkg::VALUE_W-1:0] rsp_data_ff;
   logic                        rsp_user_ff;

   logic [CellsW:0]             total;
   logic [ThrW-1:0]             thr_in;
   logic                        pass;
   logic                        known_kind;
   logic [CellsW:0]             rem_sh, rem_diff;
   logic                        ge;
   logic [SumW-1:0]             head_abs;
   logic [zwa_pkg::VALUE_W-1:0] sat_res;

   assign q_pop = (state_ff == ST_IDLE) && !q_empty;

   assign head_abs = q_head.sum[SumW-1] ? (~q_head.sum + 1'b1) : q_head.sum;

   assign total  = {1'b0, divisor_ff} + {1'b0, nulls_ff};
   assign thr_in = frac_min * total;

   assign known_kind = (kind_ff == zwa_pkg::KIND_AVG) || (kind_ff == zwa_pkg::KIND_MIN) ||
                       (kind_ff == zwa_pkg::KIND_MAX);
   // valid * 65536 >= frac_min * (valid + null)
   assign pass = (divisor_ff != '0) && known_kind &&
                 ({2'b0, divisor_ff, 16'b0} >= thr_ff);

   // one restoring step, quotient bits shift into the low end of the dividend
   assign rem_sh   = {rem_ff, dvd_ff[SumW-1]};
   assign rem_diff = rem_sh - {1'b0, divisor_ff};
   assign ge       = (rem_sh >= {1'b0, divisor_ff});

   always_comb begin
      if (!neg_ff) begin
         sat_res = (dvd_ff > 64'h7FFFFFFF) ? 32'h7FFFFFFF : dvd_ff[31:0];
      end else begin
         sat_res = (dvd_ff > 64'h80000000) ? 32'h80000000 : (~dvd_ff[31:0] + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_tready)) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (!q_empty) begin
                  neg_ff     <= q_head.sum[SumW-1];
                  dvd_ff     <= head_abs;
                  divisor_ff <= q_head.valid;
                  nulls_ff   <= q_head.nulls;
                  ext_ff     <= q_head.extreme;
                  kind_ff    <= q_head.kind;
                  state_ff   <= ST_TEST;
               end
            end
            ST_TEST: begin
               thr_ff   <= thr_in;
               state_ff <= ST_CMP;
            end
            ST_CMP: begin
               if (!pass) begin
                  res_ff   <= nodata;
                  ok_ff    <= 1'b0;
                  state_ff <= ST_DONE;
               end else if (kind_ff == zwa_pkg::KIND_AVG) begin
                  rem_ff   <= '0;
                  step_ff  <= StepW'(zwa_pkg::DIV_STEPS - 1);
                  state_ff <= ST_DIV;
               end else begin
                  res_ff   <= ext_ff;
                  ok_ff    <= 1'b1;
                  state_ff <= ST_DONE;
               end
            end
            ST_DIV: begin
               rem_ff  <= ge ? rem_diff[CellsW-1:0] : rem_sh[CellsW-1:0];
               dvd_ff  <= {dvd_ff[SumW-2:0], ge};
               step_ff <= step_ff - 1'b1;
               if (step_ff == '0) state_ff <= ST_SAT;
            end
            ST_SAT: begin
               res_ff   <= sat_res;
               ok_ff    <= 1'b1;
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_data_ff  <= res_ff;
                  rsp_user_ff  <= ok_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
